### src/apc_pkg.sv
// Shared types and constants of the packet classifier.
`default_nettype none

package apc_pkg;

  localparam int unsigned PosWidth      = 17;
  localparam int unsigned CfgIndexWidth = 4;
  localparam int unsigned MaxPayload    = 65535;
  localparam int unsigned MinDataLen    = 5;
  localparam int unsigned LenOffset     = 4;

  localparam logic [7:0] ResetStartCode    = 8'd2;
  localparam logic [7:0] ResetDataCode     = 8'd1;
  localparam logic [7:0] ResetEndCode      = 8'd3;
  localparam logic [7:0] ResetFilesizeType = 8'd0;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_VAL
  } entry_phase_t;

  typedef enum logic [1:0] {
    SZ_NONE,
    SZ_ACC,
    SZ_DONE
  } size_phase_t;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_DATA,
    KIND_END,
    KIND_BAD
  } packet_kind_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_START_CODE,
    CFG_DATA_CODE,
    CFG_END_CODE,
    CFG_FILESIZE_TYPE
  } cfg_index_t;

endpackage

`default_nettype wire

### src/apc_byte_if.sv
// Byte channel into the packet classifier.
`default_nettype none

interface apc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;

  modport source (output valid, output rx_byte, output rx_last, input ready);
  modport sink (input valid, input rx_byte, input rx_last, output ready);
endinterface

`default_nettype wire

### src/apc_report_if.sv
// Report channel out of the packet classifier.
`default_nettype none

interface apc_report_if;
  logic                  valid;
  logic                  ready;
  apc_pkg::packet_kind_t packet_kind;
  logic [7:0]            seq_index;
  logic [15:0]           payload_len;
  logic                  index_mismatch;
  logic [7:0]            entry_count;
  logic [31:0]           file_size;
  logic                  file_size_valid;

  modport source (
    output valid, output packet_kind, output seq_index, output payload_len,
    output index_mismatch, output entry_count, output file_size,
    output file_size_valid, input ready
  );
  modport sink (
    input valid, input packet_kind, input seq_index, input payload_len,
    input index_mismatch, input entry_count, input file_size,
    input file_size_valid, output ready
  );
endinterface

`default_nettype wire

### src/app_packet_classifier_core.sv
// Top level of the packet classifier: byte parser, classification and report register.
//
// Packet bytes enter on the bytes channel one per transfer; rx_last marks the
// final byte. Each packet yields exactly one transfer on the report channel,
// which says whether it was a START or END control packet (with its entry count
// and decimal file size), a DATA packet (with index, length and index mismatch
// flag) or a bad packet.
// A byte is taken in every cycle while the report register is empty or being
// emptied, so the sustained rate is one byte per cycle. The report appears in the
// cycle after the transfer of the final byte; the parser state is updated in
// that same cycle, so the next packet may start right away.
// When the receiver stalls with a report waiting, the bytes channel is held
// off as well, and no byte is taken until that report transfers.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and should only change while no packet is in progress.
// Reset sets the codes to their defaults, clears the parser and the expected
// sequence index, and empties the report register.
`default_nettype none

module app_packet_classifier_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [apc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [7:0]                        cfg_data,
  apc_byte_if.sink                               bytes,
  apc_report_if.source                           report
);

  logic [7:0] start_code;
  logic [7:0] data_code;
  logic [7:0] end_code;
  logic [7:0] filesize_type;

  logic [apc_pkg::PosWidth-1:0] byte_position;
  logic [apc_pkg::PosWidth-1:0] byte_position_next;
  logic [7:0]                   lead_byte;
  logic [7:0]                   lead_byte_next;
  logic [7:0]                   index_byte;
  logic [7:0]                   index_byte_next;
  logic [15:0]                  length_field;
  logic [15:0]                  length_field_next;
  apc_pkg::entry_phase_t        entry_phase;
  apc_pkg::entry_phase_t        entry_phase_next;
  logic [7:0]                   value_left;
  logic [7:0]                   value_left_next;
  logic [7:0]                   entry_type_now;
  logic [7:0]                   entry_type_now_next;
  logic                         last_entry_empty;
  logic                         last_entry_empty_next;
  logic [7:0]                   entry_total;
  logic [7:0]                   entry_total_next;
  logic [31:0]                  size_accum;
  logic [31:0]                  size_accum_next;
  apc_pkg::size_phase_t         size_phase;
  apc_pkg::size_phase_t         size_phase_next;
  logic [7:0]                   expected_index;
  logic [7:0]                   expected_index_next;

  logic        byte_fire;
  logic        is_digit;
  logic [35:0] size_product;
  logic        ctrl_ok;
  logic        is_data;

  apc_pkg::packet_kind_t kind_next;
  logic                  mismatch_next;
  logic [31:0]           file_size_next;
  logic                  file_size_valid_next;

  logic                  out_valid;
  apc_pkg::packet_kind_t out_kind;
  logic [7:0]            out_seq_index;
  logic [15:0]           out_payload_len;
  logic                  out_index_mismatch;
  logic [7:0]            out_entry_count;
  logic [31:0]           out_file_size;
  logic                  out_file_size_valid;

  assign bytes.ready = !out_valid || report.ready;
  assign byte_fire   = bytes.valid && bytes.ready;

  assign report.valid           = out_valid;
  assign report.packet_kind     = out_kind;
  assign report.seq_index       = out_seq_index;
  assign report.payload_len     = out_payload_len;
  assign report.index_mismatch  = out_index_mismatch;
  assign report.entry_count     = out_entry_count;
  assign report.file_size       = out_file_size;
  assign report.file_size_valid = out_file_size_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code    <= apc_pkg::ResetStartCode;
      data_code     <= apc_pkg::ResetDataCode;
      end_code      <= apc_pkg::ResetEndCode;
      filesize_type <= apc_pkg::ResetFilesizeType;
    end else if (cfg_we) begin
      case (cfg_index)
        apc_pkg::CFG_START_CODE:    start_code    <= cfg_data;
        apc_pkg::CFG_DATA_CODE:     data_code     <= cfg_data;
        apc_pkg::CFG_END_CODE:      end_code      <= cfg_data;
        apc_pkg::CFG_FILESIZE_TYPE: filesize_type <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_digit = (bytes.rx_byte >= apc_pkg::AsciiZero) &&
                    (bytes.rx_byte <= apc_pkg::AsciiNine);
  assign size_product = ({4'd0, size_accum} << 3) + ({4'd0, size_accum} << 1) +
                        {32'd0, bytes.rx_byte[3:0]};

  // Entry parser state.
  always_comb begin
    entry_phase_next = entry_phase;
    if (byte_position != '0) begin
      case (entry_phase)
        apc_pkg::PH_TYPE: entry_phase_next = apc_pkg::PH_LEN;
        apc_pkg::PH_LEN: begin
          entry_phase_next = (bytes.rx_byte == 8'd0) ? apc_pkg::PH_TYPE : apc_pkg::PH_VAL;
        end
        apc_pkg::PH_VAL: begin
          entry_phase_next = (value_left == 8'd1) ? apc_pkg::PH_TYPE : apc_pkg::PH_VAL;
        end
        default: entry_phase_next = apc_pkg::PH_TYPE;
      endcase
    end
  end

  always_comb begin
    byte_position_next    = (byte_position == '1) ? byte_position : byte_position + 1'b1;
    lead_byte_next        = lead_byte;
    index_byte_next       = index_byte;
    length_field_next     = length_field;
    value_left_next       = value_left;
    entry_type_now_next   = entry_type_now;
    last_entry_empty_next = last_entry_empty;
    entry_total_next      = entry_total;
    size_accum_next       = size_accum;
    size_phase_next       = size_phase;
    if (byte_position == '0) begin
      lead_byte_next = bytes.rx_byte;
    end else begin
      if (byte_position == apc_pkg::PosWidth'(1)) index_byte_next = bytes.rx_byte;
      if (byte_position == apc_pkg::PosWidth'(2)) begin
        length_field_next = {bytes.rx_byte, length_field[7:0]};
      end
      if (byte_position == apc_pkg::PosWidth'(3)) begin
        length_field_next = {length_field[15:8], bytes.rx_byte};
      end
      case (entry_phase)
        apc_pkg::PH_LEN: begin
          value_left_next = bytes.rx_byte;
          if (entry_total != 8'hFF) entry_total_next = entry_total + 8'd1;
          if (size_phase == apc_pkg::SZ_NONE && entry_type_now == filesize_type) begin
            size_phase_next = (bytes.rx_byte != 8'd0) ? apc_pkg::SZ_ACC : apc_pkg::SZ_DONE;
          end
          last_entry_empty_next = (bytes.rx_byte == 8'd0);
        end
        apc_pkg::PH_VAL: begin
          if (size_phase == apc_pkg::SZ_ACC) begin
            if (is_digit) begin
              size_accum_next = (size_product[35:32] != 4'd0) ? 32'hFFFF_FFFF :
                                size_product[31:0];
            end else begin
              size_phase_next = apc_pkg::SZ_DONE;
            end
          end
          value_left_next = value_left - 8'd1;
          if (value_left == 8'd1 && size_phase_next == apc_pkg::SZ_ACC) begin
            size_phase_next = apc_pkg::SZ_DONE;
          end
        end
        default: entry_type_now_next = bytes.rx_byte;
      endcase
    end
  end

  // Classification of a packet that ends with the current byte.
  always_comb begin
    ctrl_ok = (entry_phase_next == apc_pkg::PH_TYPE) && !last_entry_empty_next;
    is_data = (byte_position_next >= apc_pkg::PosWidth'(apc_pkg::MinDataLen)) &&
              (lead_byte_next == data_code) &&
              ({1'b0, length_field_next} ==
               byte_position_next - apc_pkg::PosWidth'(apc_pkg::LenOffset)) &&
              ({1'b0, length_field_next} <= apc_pkg::PosWidth'(apc_pkg::MaxPayload));
    mismatch_next        = 1'b0;
    expected_index_next  = expected_index;
    file_size_next       = 32'd0;
    file_size_valid_next = 1'b0;
    if (ctrl_ok && lead_byte_next == start_code) begin
      kind_next           = apc_pkg::KIND_START;
      expected_index_next = 8'd0;
    end else if (is_data) begin
      kind_next           = apc_pkg::KIND_DATA;
      mismatch_next       = (index_byte_next != expected_index);
      expected_index_next = expected_index + 8'd1;
    end else if (ctrl_ok && lead_byte_next == end_code) begin
      kind_next           = apc_pkg::KIND_END;
      expected_index_next = 8'd0;
    end else begin
      kind_next = apc_pkg::KIND_BAD;
    end
    if (size_phase_next != apc_pkg::SZ_NONE) begin
      file_size_next       = size_accum_next;
      file_size_valid_next = (size_accum_next != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      lead_byte        <= 8'd0;
      index_byte       <= 8'd0;
      length_field     <= 16'd0;
      entry_phase      <= apc_pkg::PH_TYPE;
      value_left       <= 8'd0;
      entry_type_now   <= 8'd0;
      last_entry_empty <= 1'b0;
      entry_total      <= 8'd0;
      size_accum       <= 32'd0;
      size_phase       <= apc_pkg::SZ_NONE;
      expected_index   <= 8'd0;
    end else if (byte_fire) begin
      if (bytes.rx_last) begin
        byte_position    <= '0;
        lead_byte        <= 8'd0;
        index_byte       <= 8'd0;
        length_field     <= 16'd0;
        entry_phase      <= apc_pkg::PH_TYPE;
        value_left       <= 8'd0;
        entry_type_now   <= 8'd0;
        last_entry_empty <= 1'b0;
        entry_total      <= 8'd0;
        size_accum       <= 32'd0;
        size_phase       <= apc_pkg::SZ_NONE;
        expected_index   <= expected_index_next;
      end else begin
        byte_position    <= byte_position_next;
        lead_byte        <= lead_byte_next;
        index_byte       <= index_byte_next;
        length_field     <= length_field_next;
        entry_phase      <= entry_phase_next;
        value_left       <= value_left_next;
        entry_type_now   <= entry_type_now_next;
        last_entry_empty <= last_entry_empty_next;
        entry_total      <= entry_total_next;
        size_accum       <= size_accum_next;
        size_phase       <= size_phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (byte_fire && bytes.rx_last) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire && bytes.rx_last) begin
      out_kind            <= kind_next;
      out_seq_index       <= (kind_next == apc_pkg::KIND_DATA) ? index_byte_next : 8'd0;
      out_payload_len     <= (kind_next == apc_pkg::KIND_DATA) ? length_field_next : 16'd0;
      out_index_mismatch  <= (kind_next == apc_pkg::KIND_DATA) && mismatch_next;
      if (kind_next == apc_pkg::KIND_START || kind_next == apc_pkg::KIND_END) begin
        out_entry_count     <= entry_total_next;
        out_file_size       <= file_size_next;
        out_file_size_valid <= file_size_valid_next;
      end else begin
        out_entry_count     <= 8'd0;
        out_file_size       <= 32'd0;
        out_file_size_valid <= 1'b0;
      end
    end
  end

  a_report_follows_last: assert property (@(posedge clk) disable iff (rst)
    byte_fire && bytes.rx_last |=> out_valid)
    else $error("No report after the final byte of a packet.");

  a_parser_cleared: assert property (@(posedge clk) disable iff (rst)
    byte_fire && bytes.rx_last |=> byte_position == '0 && size_phase == apc_pkg::SZ_NONE)
    else $error("Parser state not cleared after a packet.");

  a_control_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == apc_pkg::KIND_START || out_kind == apc_pkg::KIND_END)
    |-> out_seq_index == 8'd0 && out_payload_len == 16'd0 && !out_index_mismatch)
    else $error("Control report carries data fields.");

  a_size_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_file_size_valid |-> out_file_size != 32'd0)
    else $error("File size flagged valid while zero.");

  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    byte_fire && bytes.rx_last && kind_next == apc_pkg::KIND_DATA
    |=> expected_index == $past(expected_index) + 8'd1)
    else $error("Expected index did not advance after a data packet.");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the packet classifier: byte stream in, one checked report per packet.
module testbench;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 120;
  localparam int PrintLimit = 40;
  localparam logic [apc_pkg::CfgIndexWidth-1:0] CfgUnused = '1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_item_t;

  typedef struct {
    apc_pkg::packet_kind_t kind;
    logic [7:0]            seq;
    logic [15:0]           plen;
    logic                  mism;
    logic [7:0]            ents;
    logic [31:0]           fsize;
    logic                  fvalid;
  } report_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_we;
  logic [apc_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [7:0]                        cfg_data;

  apc_byte_if   bytes_ch ();
  apc_report_if report_ch ();

  app_packet_classifier_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .bytes(bytes_ch),
    .report(report_ch)
  );

  // Classifier model: configuration copy and per-packet parse state.
  logic [7:0]                   code_start, code_data, code_end, size_type;
  logic [apc_pkg::PosWidth-1:0] pos_cnt;
  logic [7:0]                   lead, seq_byte;
  logic [15:0]                  len_field;
  apc_pkg::entry_phase_t        tlv_phase;
  logic [7:0]                   val_left, cur_type;
  logic                         last_empty;
  logic [7:0]                   ents;
  logic [31:0]                  size_acc;
  apc_pkg::size_phase_t         size_st;
  logic [7:0]                   exp_seq;

  report_t    expected_reports[$];
  rx_item_t   tx_bytes[$];
  rx_item_t   next_item;
  logic [7:0] frame[$];
  logic [7:0] gen_seq;

  int send_idle_pct, recv_idle_pct;
  int hold_requests, holds_seen, hold_left;
  int errors, reports_checked, bytes_sent, stall_cycles;
  int kind_count[4];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_parse();
    pos_cnt    = '0;
    lead       = '0;
    seq_byte   = '0;
    len_field  = '0;
    tlv_phase  = apc_pkg::PH_TYPE;
    val_left   = '0;
    cur_type   = '0;
    last_empty = 1'b0;
    ents       = '0;
    size_acc   = '0;
    size_st    = apc_pkg::SZ_NONE;
  endfunction

  function automatic void tlv_step(input logic [7:0] b);
    logic [63:0] prod;
    case (tlv_phase)
      apc_pkg::PH_LEN: begin
        val_left = b;
        if (ents != 8'hFF) ents = ents + 8'd1;
        if (size_st == apc_pkg::SZ_NONE && cur_type == size_type) begin
          if (b != 8'd0) size_st = apc_pkg::SZ_ACC;
          else size_st = apc_pkg::SZ_DONE;
        end
        last_empty = (b == 8'd0);
        if (b == 8'd0) tlv_phase = apc_pkg::PH_TYPE;
        else tlv_phase = apc_pkg::PH_VAL;
      end
      apc_pkg::PH_VAL: begin
        if (size_st == apc_pkg::SZ_ACC) begin
          if (b >= apc_pkg::AsciiZero && b <= apc_pkg::AsciiNine) begin
            prod = 64'(size_acc) * 64'd10 + 64'(b - apc_pkg::AsciiZero);
            size_acc = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
          end else begin
            size_st = apc_pkg::SZ_DONE;
          end
        end
        val_left = val_left - 8'd1;
        if (val_left == 8'd0) begin
          tlv_phase = apc_pkg::PH_TYPE;
          if (size_st == apc_pkg::SZ_ACC) size_st = apc_pkg::SZ_DONE;
        end
      end
      default: begin
        cur_type  = b;
        tlv_phase = apc_pkg::PH_LEN;
      end
    endcase
  endfunction

  function automatic void classify_byte(input logic [7:0] b, input logic last);
    report_t r;
    int      total;
    logic    ctrl_ok, is_data;
    if (pos_cnt == '0) begin
      lead = b;
    end else begin
      if (pos_cnt == 1) seq_byte = b;
      else if (pos_cnt == 2) len_field[15:8] = b;
      else if (pos_cnt == 3) len_field[7:0] = b;
      tlv_step(b);
    end
    if (pos_cnt != '1) pos_cnt = pos_cnt + 1'b1;
    if (last) begin
      total   = int'(pos_cnt);
      ctrl_ok = (tlv_phase == apc_pkg::PH_TYPE) && !last_empty;
      is_data = total >= int'(apc_pkg::MinDataLen) && lead == code_data &&
                int'(len_field) == total - int'(apc_pkg::LenOffset) &&
                int'(len_field) <= int'(apc_pkg::MaxPayload);
      r.kind   = apc_pkg::KIND_BAD;
      r.seq    = '0;
      r.plen   = '0;
      r.mism   = 1'b0;
      r.ents   = '0;
      r.fsize  = '0;
      r.fvalid = 1'b0;
      if (ctrl_ok && lead == code_start) begin
        r.kind  = apc_pkg::KIND_START;
        exp_seq = '0;
      end else if (is_data) begin
        r.kind  = apc_pkg::KIND_DATA;
        r.seq   = seq_byte;
        r.plen  = len_field;
        r.mism  = (seq_byte != exp_seq);
        exp_seq = exp_seq + 8'd1;
      end else if (ctrl_ok && lead == code_end) begin
        r.kind  = apc_pkg::KIND_END;
        exp_seq = '0;
      end
      if (r.kind == apc_pkg::KIND_START || r.kind == apc_pkg::KIND_END) begin
        r.ents   = ents;
        r.fsize  = (size_st != apc_pkg::SZ_NONE) ? size_acc : 32'd0;
        r.fvalid = (size_st != apc_pkg::SZ_NONE) && (size_acc != 32'd0);
      end
      expected_reports.push_back(r);
      clear_parse();
    end
  endfunction

  task automatic report_error(input string what);
    errors++;
    if (errors <= PrintLimit) begin
      $display("[%0t] mismatch on report %0d: %s", $time, reports_checked, what);
    end
  endtask

  task automatic check_report();
    report_t want;
    if (expected_reports.size() == 0) begin
      report_error("report transfer with no packet outstanding");
      return;
    end
    want = expected_reports.pop_front();
    kind_count[int'(want.kind)]++;
    if (report_ch.packet_kind !== want.kind)
      report_error($sformatf("packet_kind %0d, want %0d", report_ch.packet_kind, want.kind));
    if (report_ch.seq_index !== want.seq)
      report_error($sformatf("seq_index %0d, want %0d", report_ch.seq_index, want.seq));
    if (report_ch.payload_len !== want.plen)
      report_error($sformatf("payload_len %0d, want %0d", report_ch.payload_len, want.plen));
    if (report_ch.index_mismatch !== want.mism)
      report_error($sformatf("index_mismatch %b, want %b", report_ch.index_mismatch, want.mism));
    if (report_ch.entry_count !== want.ents)
      report_error($sformatf("entry_count %0d, want %0d", report_ch.entry_count, want.ents));
    if (report_ch.file_size !== want.fsize)
      report_error($sformatf("file_size %0d, want %0d", report_ch.file_size, want.fsize));
    if (report_ch.file_size_valid !== want.fvalid)
      report_error($sformatf("file_size_valid %b, want %b", report_ch.file_size_valid,
                             want.fvalid));
    reports_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bytes_ch.valid <= 1'b0;
    end else begin
      if (bytes_ch.valid && bytes_ch.ready) begin
        classify_byte(bytes_ch.rx_byte, bytes_ch.rx_last);
        bytes_sent++;
      end
      if (!bytes_ch.valid || bytes_ch.ready) begin
        if (tx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = tx_bytes.pop_front();
          bytes_ch.valid   <= 1'b1;
          bytes_ch.rx_byte <= next_item.data;
          bytes_ch.rx_last <= next_item.last;
        end else begin
          bytes_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
      hold_left       <= 0;
      holds_seen      <= 0;
    end else begin
      if (report_ch.valid && report_ch.ready) check_report();
      if (holds_seen != hold_requests) begin
        holds_seen      <= hold_requests;
        hold_left       <= HoldCycles;
        report_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left       <= hold_left - 1;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (bytes_ch.valid && bytes_ch.ready) || (report_ch.valid && report_ch.ready) ||
        (tx_bytes.size() == 0 && !bytes_ch.valid && expected_reports.size() == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Timeout: no transfer for %0d cycles.", StallLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [apc_pkg::CfgIndexWidth-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      apc_pkg::CFG_START_CODE:    code_start = val;
      apc_pkg::CFG_DATA_CODE:     code_data = val;
      apc_pkg::CFG_END_CODE:      code_end = val;
      apc_pkg::CFG_FILESIZE_TYPE: size_type = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    while (tx_bytes.size() != 0 || bytes_ch.valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic begin_frame(input logic [7:0] code);
    frame.delete();
    frame.push_back(code);
  endtask

  task automatic send_frame();
    rx_item_t item;
    int       i;
    for (i = 0; i < frame.size(); i++) begin
      item.data = frame[i];
      item.last = (i == frame.size() - 1);
      tx_bytes.push_back(item);
    end
  endtask

  task automatic add_entry(input logic [7:0] t, input logic [7:0] n, input int digits);
    int j;
    frame.push_back(t);
    frame.push_back(n);
    for (j = 0; j < int'(n); j++) begin
      if (j < digits) frame.push_back(apc_pkg::AsciiZero + 8'($urandom_range(9)));
      else frame.push_back(8'($urandom));
    end
  endtask

  task automatic add_number(input logic [7:0] t, input string s);
    int j;
    frame.push_back(t);
    frame.push_back(8'(s.len()));
    for (j = 0; j < s.len(); j++) frame.push_back(s[j]);
  endtask

  task automatic data_frame(input logic [7:0] idx, input logic [15:0] field, input int n);
    int j;
    begin_frame(code_data);
    frame.push_back(idx);
    frame.push_back(field[15:8]);
    frame.push_back(field[7:0]);
    for (j = 0; j < n; j++) frame.push_back(8'($urandom));
  endtask

  task automatic make_control(input logic [7:0] code);
    int         k, i, n;
    logic [7:0] t;
    begin_frame(code);
    k = $urandom_range(4);
    for (i = 0; i < k; i++) begin
      if ($urandom_range(2) == 0) t = size_type;
      else t = 8'($urandom);
      if (i < k - 1 && $urandom_range(5) == 0) n = 0;
      else n = $urandom_range(12, 1);
      if (t == size_type && $urandom_range(3) != 0) add_entry(t, 8'(n), n);
      else add_entry(t, 8'(n), $urandom_range(n));
    end
    gen_seq = '0;
  endtask

  task automatic make_data();
    int          n;
    logic [15:0] field;
    logic [7:0]  idx;
    if ($urandom_range(29) == 0) n = $urandom_range(80, 40);
    else n = $urandom_range(12, 1);
    field = 16'(n);
    if ($urandom_range(11) == 0) field = 16'($urandom);
    if ($urandom_range(9) == 0) idx = 8'($urandom);
    else idx = gen_seq;
    gen_seq = gen_seq + 8'd1;
    data_frame(idx, field, n);
  endtask

  task automatic make_noise();
    int n, j;
    frame.delete();
    n = $urandom_range(8, 1);
    for (j = 0; j < n; j++) frame.push_back(8'($urandom));
  endtask

  task automatic make_broken();
    if ($urandom_range(1) == 1) make_data();
    else if ($urandom_range(1) == 1) make_control(code_start);
    else make_control(code_end);
    case ($urandom_range(2))
      0: frame[$urandom_range(frame.size() - 1)] = 8'($urandom);
      1: if (frame.size() > 1) void'(frame.pop_back());
      default: frame.push_back(8'($urandom));
    endcase
  endtask

  task automatic random_phase(input int min_bytes, input int min_frames);
    int nb, nf, r;
    nb = 0;
    nf = 0;
    while (nb < min_bytes || nf < min_frames) begin
      r = $urandom_range(99);
      if (r < 15) make_control(code_start);
      else if (r < 65) make_data();
      else if (r < 75) make_control(code_end);
      else if (r < 85) make_noise();
      else make_broken();
      send_frame();
      nb += frame.size();
      nf++;
    end
  endtask

  task automatic run_directed();
    begin_frame(code_start);
    send_frame();
    begin_frame(code_end);
    send_frame();
    begin_frame(code_start);
    add_number(size_type, "1234");
    add_entry(8'h41, 8'd2, 0);
    send_frame();
    begin_frame(code_start);
    add_number(size_type, "");
    add_entry(8'h05, 8'd1, 0);
    send_frame();
    begin_frame(code_start);
    add_number(size_type, "a12");
    send_frame();
    begin_frame(code_end);
    add_number(size_type, "99999999999");
    send_frame();
    begin_frame(code_start);
    add_number(size_type, "7");
    add_number(size_type, "8");
    send_frame();
    begin_frame(code_start);
    add_number(size_type, "0");
    send_frame();
    begin_frame(code_end);
    add_number(size_type, "42x9");
    send_frame();
    begin_frame(code_end);
    add_entry(8'h05, 8'd0, 0);
    send_frame();
    begin_frame(code_start);
    add_entry(8'h05, 8'd3, 0);
    void'(frame.pop_back());
    send_frame();
    data_frame(8'd0, 16'd1, 1);
    send_frame();
    data_frame(8'd5, 16'd1, 1);
    send_frame();
    data_frame(8'd2, 16'd3, 2);
    send_frame();
    data_frame(8'd0, 16'd0, 0);
    send_frame();
    data_frame(8'hFF, 16'd1, 1);
    send_frame();
    begin_frame(8'hFF);
    send_frame();
    begin_frame(8'h00);
    send_frame();
  endtask

  initial begin : stimulus
    int i;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    bytes_ch.valid   = 1'b0;
    bytes_ch.rx_byte = '0;
    bytes_ch.rx_last = 1'b0;
    report_ch.ready  = 1'b0;
    send_idle_pct    = 31;
    recv_idle_pct    = 58;
    hold_requests    = 0;
    errors           = 0;
    reports_checked  = 0;
    bytes_sent       = 0;
    stall_cycles     = 0;
    gen_seq          = '0;
    for (i = 0; i < 4; i++) kind_count[i] = 0;
    code_start = apc_pkg::ResetStartCode;
    code_data  = apc_pkg::ResetDataCode;
    code_end   = apc_pkg::ResetEndCode;
    size_type  = apc_pkg::ResetFilesizeType;
    exp_seq    = '0;
    clear_parse();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    drain();
    write_reg(apc_pkg::CFG_START_CODE, 8'h00);
    write_reg(apc_pkg::CFG_DATA_CODE, 8'hFF);
    write_reg(apc_pkg::CFG_END_CODE, 8'h80);
    write_reg(apc_pkg::CFG_FILESIZE_TYPE, 8'hFF);
    write_reg(CfgUnused, 8'h11);
    random_phase(90, 8);
    drain();

    send_idle_pct = 58;
    recv_idle_pct = 31;
    // Start and data share a code here, so the start test must win.
    write_reg(apc_pkg::CFG_START_CODE, 8'h41);
    write_reg(apc_pkg::CFG_DATA_CODE, 8'h41);
    write_reg(apc_pkg::CFG_END_CODE, 8'h42);
    write_reg(apc_pkg::CFG_FILESIZE_TYPE, 8'h31);
    random_phase(90, 8);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(apc_pkg::CFG_START_CODE, 8'hFF);
    write_reg(apc_pkg::CFG_DATA_CODE, 8'h00);
    write_reg(apc_pkg::CFG_END_CODE, 8'h00);
    write_reg(apc_pkg::CFG_FILESIZE_TYPE, 8'h7F);
    random_phase(90, 8);
    drain();

    hold_requests++;
    for (i = 0; i < 8; i++) begin
      make_data();
      send_frame();
    end
    drain();

    $display("Sent %0d bytes; checked %0d reports: %0d start, %0d data, %0d end, %0d bad.",
             bytes_sent, reports_checked, kind_count[0], kind_count[1], kind_count[2],
             kind_count[3]);
    $display("Covered four code settings, three idle mixes and a long report stall.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
